/* sv/fsp_pkg.sv */
// Shared constants, types and a helper function for the format string printer.
`default_nettype none

package fsp_pkg;

    localparam logic [1:0] CMD_FORMAT  = 2'd0;
    localparam logic [1:0] CMD_RAW     = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;

    localparam int ARG_W       = 64;
    localparam int BIN_W       = 32;
    localparam int BCD_DIGITS  = 10;
    localparam int BCD_W       = 4 * BCD_DIGITS;
    localparam int DIG_NIBBLES = ARG_W / 4;
    localparam int PFX_BYTES   = 6;
    localparam int PFX_W       = 8 * PFX_BYTES;
    localparam int COUNT_W     = 31;

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_C       = 8'h63;
    localparam logic [7:0] CH_D       = 8'h64;
    localparam logic [7:0] CH_I       = 8'h69;
    localparam logic [7:0] CH_P       = 8'h70;
    localparam logic [7:0] CH_S       = 8'h73;
    localparam logic [7:0] CH_U       = 8'h75;
    localparam logic [7:0] CH_X_LO    = 8'h78;
    localparam logic [7:0] CH_X_UP    = 8'h58;

    localparam logic [PFX_W-1:0] STR_NIL  = {"(nil)", 8'h00};
    localparam logic [PFX_W-1:0] STR_NULL = "(null)";
    localparam logic [PFX_W-1:0] STR_HEX  = {"0x", 32'h0};

    typedef struct packed {
        logic             go;
        logic             dec;
        logic [ARG_W-1:0] value;
    } t_dig_req;

    typedef struct packed {
        logic       busy;
        logic       ready;
        logic [3:0] nibble;
        logic       last;
    } t_dig_stat;

    function automatic logic [7:0] fsp_hex_char(input logic [3:0] nib, input logic upper);
        logic [7:0] c;
        if (nib < 4'd10) begin
            c = 8'h30 + {4'h0, nib};
        end else if (upper) begin
            c = 8'h37 + {4'h0, nib};
        end else begin
            c = 8'h57 + {4'h0, nib};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* sv/fsp_digits.sv */
// Digit unit: shift/add-3 binary to BCD, leading zero skip and digit delivery.
`default_nettype none

module fsp_digits
    import fsp_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_dig_req  i_req,
    input  wire logic      i_take,
    output t_dig_stat      o_stat
);

    typedef enum logic [1:0] {D_IDLE, D_DABBLE, D_SKIP, D_READY} t_dstate;

    localparam logic [4:0] REM_FULL = 5'(DIG_NIBBLES);
    localparam logic [4:0] BIT_LAST = 5'(BIN_W - 1);

    t_dstate          r_state;
    logic [BIN_W-1:0] r_bin;
    logic [ARG_W-1:0] r_dig;
    logic [4:0]       r_bit_cnt;
    logic [4:0]       r_rem;
    logic [BCD_W-1:0] n_adj;

    always_comb begin
        for (int k = 0; k < BCD_DIGITS; k++) begin
            if (r_dig[4*k +: 4] >= 4'd5) begin
                n_adj[4*k +: 4] = r_dig[4*k +: 4] + 4'd3;
            end else begin
                n_adj[4*k +: 4] = r_dig[4*k +: 4];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
        end else begin
            case (r_state)
                D_IDLE: begin
                    if (i_req.go) begin
                        if (i_req.dec) begin
                            r_bin     <= i_req.value[BIN_W-1:0];
                            r_dig     <= '0;
                            r_bit_cnt <= BIT_LAST;
                            r_state   <= D_DABBLE;
                        end else begin
                            r_dig   <= i_req.value;
                            r_rem   <= REM_FULL;
                            r_state <= D_SKIP;
                        end
                    end
                end
                D_DABBLE: begin
                    r_dig[BCD_W-1:0] <= {n_adj[BCD_W-2:0], r_bin[BIN_W-1]};
                    r_bin            <= {r_bin[BIN_W-2:0], 1'b0};
                    if (r_bit_cnt == 5'd0) begin
                        r_rem   <= REM_FULL;
                        r_state <= D_SKIP;
                    end else begin
                        r_bit_cnt <= r_bit_cnt - 5'd1;
                    end
                end
                D_SKIP: begin
                    if (r_dig[ARG_W-1 -: 4] == 4'd0 && r_rem > 5'd1) begin
                        r_dig <= {r_dig[ARG_W-5:0], 4'd0};
                        r_rem <= r_rem - 5'd1;
                    end else begin
                        r_state <= D_READY;
                    end
                end
                D_READY: begin
                    if (i_take) begin
                        if (r_rem == 5'd1) begin
                            r_state <= D_IDLE;
                        end else begin
                            r_dig <= {r_dig[ARG_W-5:0], 4'd0};
                            r_rem <= r_rem - 5'd1;
                        end
                    end
                end
                default: r_state <= D_IDLE;
            endcase
        end
    end

    assign o_stat.busy   = (r_state != D_IDLE);
    assign o_stat.ready  = (r_state == D_READY);
    assign o_stat.nibble = r_dig[ARG_W-1 -: 4];
    assign o_stat.last   = (r_rem == 5'd1);

    a_ready_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == D_READY |-> (r_rem != 5'd0 && r_rem <= REM_FULL))
        else $error("digit count out of range while delivering");

    a_bcd_top_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == D_DABBLE |-> r_dig[ARG_W-1:BCD_W] == '0)
        else $error("upper digits not clear during conversion");

endmodule

`default_nettype wire

/* sv/format_string_printer.sv */
// Top level: format byte decode, prefix and digit emission, running byte count.
//
// Input channel: i_valid / o_stall with i_command, i_in_byte, i_arg_value. A
// transaction completes when i_valid is high and o_stall is low. Output channel:
// o_valid / i_stall with o_out_char, o_is_last, o_total_count, one character per
// transaction; o_is_last marks the final character caused by one input item.
// One item at a time: o_stall is high from acceptance until the last character
// of that item has been loaded into the output register.
// A literal or prefixed conversion loads its first character from the registered
// prefix into the output register. Decimal conversions run the shift/add-3 loop
// in the digit unit, then skip leading zeros before the first digit; hex
// conversions need only the zero skip. After that one character leaves per
// cycle while the receiver does not stall. An item that emits nothing leaves
// o_stall low.
// A stalled receiver holds the output register; emission pauses and resumes.
// Reset clears the pending percent flag, the byte count and the output valid.
// The restart command does the same for flag and count and emits nothing.
`default_nettype none

module format_string_printer
    import fsp_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [1:0]         i_command,
    input  wire logic [7:0]         i_in_byte,
    input  wire logic [ARG_W-1:0]   i_arg_value,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [7:0]              o_out_char,
    output logic                    o_is_last,
    output logic [COUNT_W-1:0]      o_total_count
);

    typedef enum logic [1:0] {S_IDLE, S_PREFIX, S_DIGITS} t_state;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    t_state             r_state;
    logic               r_pending;
    logic [COUNT_W-1:0] r_count;
    logic [PFX_W-1:0]   r_pfx;
    logic [2:0]         r_pfx_len;
    logic               r_has_dig;
    logic               r_upper;
    logic               r_out_valid;
    logic [7:0]         r_out_char;
    logic               r_out_last;
    logic [COUNT_W-1:0] r_out_count;

    logic               accept;
    logic               n_pending;
    logic               n_clear;
    logic [PFX_W-1:0]   n_pfx;
    logic [2:0]         n_pfx_len;
    logic               n_has_dig;
    logic               n_upper;
    t_dig_req           dig_req;
    t_dig_stat          dig_stat;
    logic [BIN_W-1:0]   arg_lo;
    logic [BIN_W-1:0]   arg_neg;

    logic               slot_free;
    logic               load;
    logic               take;
    logic [7:0]         n_char;
    logic               n_last;
    logic [COUNT_W-1:0] n_count;

    assign o_stall = (r_state != S_IDLE);
    assign accept  = i_valid && !o_stall;
    assign arg_lo  = i_arg_value[BIN_W-1:0];
    assign arg_neg = ~arg_lo + 32'd1;

    always_comb begin
        n_pending = r_pending;
        n_clear   = 1'b0;
        n_pfx     = '0;
        n_pfx_len = 3'd0;
        n_has_dig = 1'b0;
        n_upper   = 1'b0;
        dig_req   = '0;
        if (accept) begin
            case (i_command)
                CMD_RESTART: begin
                    n_pending = 1'b0;
                    n_clear   = 1'b1;
                end
                CMD_RAW: begin
                    n_pfx     = {i_in_byte, 40'h0};
                    n_pfx_len = 3'd1;
                end
                CMD_FORMAT: begin
                    if (i_in_byte == CH_NUL) begin
                        n_pending = 1'b0;
                    end else if (r_pending) begin
                        n_pending = 1'b0;
                        case (i_in_byte)
                            CH_C: begin
                                n_pfx     = {i_arg_value[7:0], 40'h0};
                                n_pfx_len = 3'd1;
                            end
                            CH_D, CH_I: begin
                                n_has_dig   = 1'b1;
                                dig_req.go  = 1'b1;
                                dig_req.dec = 1'b1;
                                if (arg_lo[BIN_W-1]) begin
                                    n_pfx         = {CH_MINUS, 40'h0};
                                    n_pfx_len     = 3'd1;
                                    dig_req.value = {32'h0, arg_neg};
                                end else begin
                                    dig_req.value = {32'h0, arg_lo};
                                end
                            end
                            CH_U: begin
                                n_has_dig     = 1'b1;
                                dig_req.go    = 1'b1;
                                dig_req.dec   = 1'b1;
                                dig_req.value = {32'h0, arg_lo};
                            end
                            CH_X_LO, CH_X_UP: begin
                                n_has_dig     = 1'b1;
                                n_upper       = (i_in_byte == CH_X_UP);
                                dig_req.go    = 1'b1;
                                dig_req.value = {32'h0, arg_lo};
                            end
                            CH_P: begin
                                if (i_arg_value == '0) begin
                                    n_pfx     = STR_NIL;
                                    n_pfx_len = 3'd5;
                                end else begin
                                    n_pfx         = STR_HEX;
                                    n_pfx_len     = 3'd2;
                                    n_has_dig     = 1'b1;
                                    dig_req.go    = 1'b1;
                                    dig_req.value = i_arg_value;
                                end
                            end
                            CH_S: begin
                                if (i_arg_value == '0) begin
                                    n_pfx     = STR_NULL;
                                    n_pfx_len = 3'd6;
                                end
                            end
                            default: begin
                                n_pfx     = {i_in_byte, 40'h0};
                                n_pfx_len = 3'd1;
                            end
                        endcase
                    end else if (i_in_byte == CH_PERCENT) begin
                        n_pending = 1'b1;
                    end else begin
                        n_pfx     = {i_in_byte, 40'h0};
                        n_pfx_len = 3'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    fsp_digits u_digits (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (dig_req),
        .i_take  (take),
        .o_stat  (dig_stat)
    );

    assign slot_free = !r_out_valid || !i_stall;
    assign n_count   = (r_count == COUNT_MAX) ? r_count : r_count + 31'd1;

    always_comb begin
        load   = 1'b0;
        take   = 1'b0;
        n_char = r_pfx[PFX_W-1 -: 8];
        n_last = 1'b0;
        case (r_state)
            S_PREFIX: begin
                load   = slot_free;
                n_last = (r_pfx_len == 3'd1) && !r_has_dig;
            end
            S_DIGITS: begin
                load   = slot_free && dig_stat.ready;
                take   = load;
                n_char = fsp_hex_char(dig_stat.nibble, r_upper);
                n_last = dig_stat.last;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pending   <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_pending <= n_pending;
            if (load) begin
                r_out_valid <= 1'b1;
                r_out_char  <= n_char;
                r_out_last  <= n_last;
                r_out_count <= n_count;
                r_count     <= n_count;
            end else if (slot_free) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (n_clear) begin
                        r_count <= '0;
                    end
                    r_pfx     <= n_pfx;
                    r_pfx_len <= n_pfx_len;
                    r_has_dig <= n_has_dig;
                    r_upper   <= n_upper;
                    if (n_pfx_len != 3'd0) begin
                        r_state <= S_PREFIX;
                    end else if (n_has_dig) begin
                        r_state <= S_DIGITS;
                    end
                end
                S_PREFIX: begin
                    if (load) begin
                        r_pfx     <= {r_pfx[PFX_W-9:0], 8'h0};
                        r_pfx_len <= r_pfx_len - 3'd1;
                        if (r_pfx_len == 3'd1) begin
                            r_state <= r_has_dig ? S_DIGITS : S_IDLE;
                        end
                    end
                end
                S_DIGITS: begin
                    if (load && dig_stat.last) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid       = r_out_valid;
    assign o_out_char    = r_out_char;
    assign o_is_last     = r_out_last;
    assign o_total_count = r_out_count;

    a_idle_digits_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> !dig_stat.busy)
        else $error("digit unit busy while no item is in progress");

    a_last_ends_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && n_last) |=> r_state == S_IDLE)
        else $error("item continued after its last character");

    a_count_no_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0 && !n_clear) |=> r_count != '0)
        else $error("byte count wrapped");

endmodule

`default_nettype wire
